// ===== hdl/bmp24sp_pkg.sv =====
package bmp24sp_pkg;

	// Largest width or height accepted is 2**DIM_BITS-1
	localparam int DIM_BITS = 16;

	// File format constants
	localparam int HDR_LEN = 54;
	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;
	localparam logic [15:0] PLANES_REQ = 16'd1;
	localparam logic [15:0] DEPTH_REQ = 16'd24;

	// Result queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int MAX_RES = 2;

	// Output bus widths
	localparam int OUT_DATA_BITS = 91;
	localparam int OUT_TDATA_W = ((OUT_DATA_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_PIXEL,
		KIND_HEADER,
		KIND_ERROR,
		KIND_DONE
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_MAGIC,
		ERR_OFFSET,
		ERR_PLANES,
		ERR_DEPTH,
		ERR_SIZE,
		ERR_TRUNC,
		ERR_TOO_LARGE
	} err_t;

	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] column;
		logic [15:0] row;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last_of_run;
	} res_t;

	// Results produced by one byte, lowest slot first
	typedef struct packed {
		logic [1:0]        num;
		res_t [MAX_RES-1:0] res;
	} push_t;

endpackage

// ===== hdl/bmp24sp_core.sv =====
module bmp24sp_core import bmp24sp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	input  logic       room,
	output push_t      push
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	// Input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       proc;

	// Parser state
	phase_t              phase_q, phase_n;
	logic [5:0]          hpos_q, hpos_n;
	logic                magic_q, magic_n;
	logic [31:0]         size_q, size_n;
	logic [31:0]         offs_q, offs_n;
	logic [31:0]         wid_q, wid_n;
	logic [31:0]         hgt_q, hgt_n;
	logic [15:0]         planes_q, planes_n;
	logic [15:0]         depth_q, depth_n;
	logic [31:0]         bir_q, bir_n;
	logic [DIM_BITS-1:0] col_q, col_n;
	logic [DIM_BITS-1:0] rowc_q, rowc_n;
	logic [1:0]          chan_q, chan_n;
	logic [7:0]          blue_q, blue_n;
	logic [7:0]          green_q, green_n;

	// Row geometry derived from the header, settled long before header end
	logic [33:0] row3_q;
	logic [31:0] padded_q;
	logic [31:0] prod_q;
	logic [31:0] pad_sum;

	// Per-byte results
	res_t       slot [MAX_RES];
	logic [1:0] num_n;
	logic [1:0] lane;
	err_t       verdict;
	logic [31:0]         bir_inc;
	logic [DIM_BITS-1:0] rowc_inc;

	function automatic res_t blank_res(kind_t k, err_t e);
		res_t r;
		r = '0;
		r.kind = k;
		r.error_code = e;
		return r;
	endfunction

	assign proc = vld_s1 && room;
	assign in_ready = !vld_s1 || proc;

	// Hold the incoming item until the queue can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= data_byte;
			eof_s1 <= end_of_file;
		end
	end

	// Track row size and expected pixel bytes from the collected width and height
	assign pad_sum = row3_q[31:0] + 32'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row3_q <= '0;
			padded_q <= '0;
			prod_q <= '0;
		end else begin
			row3_q <= {2'b00, wid_q} + {1'b0, wid_q, 1'b0};
			padded_q <= {pad_sum[31:2], 2'b00};
			prod_q <= padded_q * hgt_q;
		end
	end

	assign lane = hpos_q[1:0] + 2'd2;
	assign bir_inc = bir_q + 32'd1;
	assign rowc_inc = rowc_q + DIM_BITS'(1);

	// Header checks, in priority order
	always_comb begin
		if (!magic_q) begin
			verdict = ERR_MAGIC;
		end else if (offs_q != 32'(HDR_LEN)) begin
			verdict = ERR_OFFSET;
		end else if (planes_q != PLANES_REQ) begin
			verdict = ERR_PLANES;
		end else if (depth_q != DEPTH_REQ) begin
			verdict = ERR_DEPTH;
		end else if (32'(HDR_LEN) + prod_q != size_q) begin
			verdict = ERR_SIZE;
		end else if ((wid_q >> DIM_BITS) != 32'd0 || (hgt_q >> DIM_BITS) != 32'd0) begin
			verdict = ERR_TOO_LARGE;
		end else begin
			verdict = ERR_NONE;
		end
	end

	// Next state and results for the byte in the input register
	always_comb begin
		phase_n = phase_q;
		hpos_n = hpos_q;
		magic_n = magic_q;
		size_n = size_q;
		offs_n = offs_q;
		wid_n = wid_q;
		hgt_n = hgt_q;
		planes_n = planes_q;
		depth_n = depth_q;
		bir_n = bir_q;
		col_n = col_q;
		rowc_n = rowc_q;
		chan_n = chan_q;
		blue_n = blue_q;
		green_n = green_q;
		num_n = 2'd0;
		slot[0] = blank_res(KIND_PIXEL, ERR_NONE);
		slot[1] = blank_res(KIND_PIXEL, ERR_NONE);

		case (phase_q)
			PH_HEADER: begin
				hpos_n = hpos_q + 6'd1;
				case (hpos_q) inside
					6'd0: if (byte_s1 != MAGIC_B) magic_n = 1'b0;
					6'd1: if (byte_s1 != MAGIC_M) magic_n = 1'b0;
					[6'd2:6'd5]: size_n[{lane, 3'b000} +: 8] = byte_s1;
					[6'd10:6'd13]: offs_n[{lane, 3'b000} +: 8] = byte_s1;
					[6'd18:6'd21]: wid_n[{lane, 3'b000} +: 8] = byte_s1;
					[6'd22:6'd25]: hgt_n[{lane, 3'b000} +: 8] = byte_s1;
					[6'd26:6'd27]: planes_n[{hpos_q[0], 3'b000} +: 8] = byte_s1;
					[6'd28:6'd29]: depth_n[{hpos_q[0], 3'b000} +: 8] = byte_s1;
					default: ;
				endcase
				// Judge the header on its final byte
				if (hpos_q == 6'(HDR_LEN - 1)) begin
					if (verdict != ERR_NONE) begin
						slot[num_n[0]] = blank_res(KIND_ERROR, verdict);
						num_n = num_n + 2'd1;
						phase_n = PH_DONE;
					end else begin
						slot[num_n[0]] = blank_res(KIND_HEADER, ERR_NONE);
						slot[num_n[0]].image_width = wid_q[15:0];
						slot[num_n[0]].image_height = hgt_q[15:0];
						num_n = num_n + 2'd1;
						if (hgt_q == 32'd0 || padded_q == 32'd0) begin
							slot[num_n[0]] = blank_res(KIND_DONE, ERR_NONE);
							num_n = num_n + 2'd1;
							phase_n = PH_DONE;
						end else begin
							phase_n = PH_PIXELS;
						end
					end
				end
			end
			PH_PIXELS: begin
				// Gather B, G, R and emit on red; pad bytes fall outside
				if ({2'b00, bir_q} < row3_q) begin
					case (chan_q)
						2'd0: begin
							blue_n = byte_s1;
							chan_n = 2'd1;
						end
						2'd1: begin
							green_n = byte_s1;
							chan_n = 2'd2;
						end
						default: begin
							slot[num_n[0]] = blank_res(KIND_PIXEL, ERR_NONE);
							slot[num_n[0]].red = byte_s1;
							slot[num_n[0]].green = green_q;
							slot[num_n[0]].blue = blue_q;
							slot[num_n[0]].column = 16'(col_q);
							slot[num_n[0]].row = 16'(rowc_q);
							num_n = num_n + 2'd1;
							col_n = col_q + DIM_BITS'(1);
							chan_n = 2'd0;
						end
					endcase
				end
				// Advance to the next row at the end of the padded row
				if (bir_inc == padded_q) begin
					bir_n = '0;
					col_n = '0;
					chan_n = 2'd0;
					rowc_n = rowc_inc;
					if (rowc_inc == hgt_q[DIM_BITS-1:0]) begin
						slot[num_n[0]] = blank_res(KIND_DONE, ERR_NONE);
						num_n = num_n + 2'd1;
						phase_n = PH_DONE;
					end
				end else begin
					bir_n = bir_inc;
				end
			end
			default: ;
		endcase

		// Flag a short stream, then start over for the next file
		if (eof_s1) begin
			if (phase_n != PH_DONE) begin
				slot[num_n[0]] = blank_res(KIND_ERROR, ERR_TRUNC);
				num_n = num_n + 2'd1;
			end
			phase_n = PH_HEADER;
			hpos_n = '0;
			magic_n = 1'b1;
			size_n = '0;
			offs_n = '0;
			wid_n = '0;
			hgt_n = '0;
			planes_n = '0;
			depth_n = '0;
			bir_n = '0;
			col_n = '0;
			rowc_n = '0;
			chan_n = 2'd0;
			blue_n = '0;
			green_n = '0;
		end

		if (num_n == 2'd1) slot[0].last_of_run = 1'b1;
		if (num_n == 2'd2) slot[1].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q <= '0;
			magic_q <= 1'b1;
			size_q <= '0;
			offs_q <= '0;
			wid_q <= '0;
			hgt_q <= '0;
			planes_q <= '0;
			depth_q <= '0;
			bir_q <= '0;
			col_q <= '0;
			rowc_q <= '0;
			chan_q <= 2'd0;
			blue_q <= '0;
			green_q <= '0;
		end else if (proc) begin
			phase_q <= phase_n;
			hpos_q <= hpos_n;
			magic_q <= magic_n;
			size_q <= size_n;
			offs_q <= offs_n;
			wid_q <= wid_n;
			hgt_q <= hgt_n;
			planes_q <= planes_n;
			depth_q <= depth_n;
			bir_q <= bir_n;
			col_q <= col_n;
			rowc_q <= rowc_n;
			chan_q <= chan_n;
			blue_q <= blue_n;
			green_q <= green_n;
		end
	end

	always_comb begin
		push.num = proc ? num_n : 2'd0;
		push.res[0] = slot[0];
		push.res[1] = slot[1];
	end

endmodule

// ===== hdl/bmp24sp_fifo.sv =====
module bmp24sp_fifo import bmp24sp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               pop;

	assign out_valid = cnt_q != '0;
	assign out_res = mem[rp_q];
	assign pop = out_valid && out_ready;
	assign room = cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_RES);

	// Write up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) mem[wp_q] <= push.res[0];
		if (push.num == 2'd2) mem[wp_q + FIFO_AW'(1)] <= push.res[1];
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + FIFO_AW'(push.num);
			if (pop) rp_q <= rp_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (FIFO_AW + 1)'(push.num) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

// ===== hdl/bmp24_stream_parser_unit.sv =====
// 24-bit BMP stream parser. Feed the file one byte per item on the s_axis side
// with tlast on the final byte; the first 54 bytes are taken as the header,
// checked (magic, pixel offset 54, one plane, 24 bpp, file size against
// padded rows times height, dimensions within limit), and answered with a
// header-accepted or error result. Pixel bytes then come out as one RGB
// result per B,G,R triple with column and row in stored row order, pad bytes
// dropped, and an image-complete result after the last row. A file that ends
// early gets a truncated error; drop pixels already taken in that case. The
// block takes one byte per clock while the queue has room: each byte passes
// an input register, then counter and compare logic, into a four-entry
// result queue. Bytes that give two results (header accepted with image
// complete, last pixel with image complete, or a result followed by a
// truncated error) push two entries into the queue, and input pauses
// whenever the queue has fewer than two free entries.
module bmp24_stream_parser_unit import bmp24sp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // data_byte
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// error_code, red, green, blue, column, row, image_width, image_height, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser,  // kind
	output logic                   m_axis_tlast
);

	push_t push;
	logic  room;
	res_t  res;

	bmp24sp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.data_byte   (s_axis_tdata),
		.end_of_file (s_axis_tlast),
		.room        (room),
		.push        (push)
	);

	bmp24sp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// Pack the result item onto the master bus
	assign m_axis_tdata = OUT_TDATA_W'({res.image_height, res.image_width, res.row,
		res.column, res.blue, res.green, res.red, res.error_code});
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last_of_run;

endmodule
